// ----- src/tws_pkg.sv -----
// Shared types and constants for the timing wheel scheduler.
// No dependencies; the other files that use it refer to it by scoped names.
`default_nettype none

package tws_pkg;

    localparam int INTERVAL_W  = 24;  // interval field, also rotation width
    localparam int TID_W       = 4;
    localparam int NUM_W       = 4;   // timer_number field
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int OFS_FIELD_W = 7;   // holds a slot offset of up to 127
    localparam int MAX_RESULTS = 16;  // expiry words reported per tick
    localparam int RES_CNT_W   = 5;   // counts up to MAX_RESULTS

    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_REJECTED  = 3'd1,
        ST_FULL      = 3'd2,
        ST_EXPIRED   = 3'd3,
        ST_DELETED   = 3'd4,
        ST_NOT_FOUND = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ADD    = 2'd1,
        OP_DELETE = 2'd2,
        OP_REJECT = 2'd3
    } t_op;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        t_op                    op;
        logic [INTERVAL_W-1:0]  rot;     // (interval-1) / slots
        logic [OFS_FIELD_W-1:0] offset;  // (interval-1) % slots + 1
        logic                   rep;
        logic [TID_W-1:0]       tid;
    } t_cmd;

endpackage

`default_nettype wire

// ----- src/tws_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/tws_fifo.sv -----
// Two-deep command queue between the front and back ends.
// No dependencies.
`default_nettype none

module tws_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr_valid,
    output logic                  o_wr_ready,
    input  wire logic [WIDTH-1:0] i_wr_data,
    output logic                  o_rd_valid,
    input  wire logic             i_rd_ready,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             wr_en;
    logic             rd_en;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_data  = r_mem[r_rp];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wp <= ~r_wp;
            end
            if (rd_en) begin
                r_rp <= ~r_rp;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
        if (wr_en) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/tws_front.sv -----
// Front end: accepts input words, classifies them and works out the
// rotation and slot offset of an add by a reciprocal multiply. Uses tws_pkg.
`default_nettype none

module tws_front #(
    parameter int WHEEL_SLOTS = 60
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [31:0]                      i_s_axis_tdata,
    input  wire logic [tws_pkg::MODE_W-1:0]       i_s_axis_tuser,
    output logic                                  o_cmd_valid,
    input  wire logic                             i_cmd_ready,
    output tws_pkg::t_cmd                         o_cmd
);

    localparam int REM_W  = $clog2(WHEEL_SLOTS);
    // ceil(2^SHIFT / slots) gives the exact quotient of any 24-bit dividend
    localparam int SHIFT  = tws_pkg::INTERVAL_W + $clog2(WHEEL_SLOTS);
    localparam int PROD_W = 2 * tws_pkg::INTERVAL_W + 1;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + 64'(WHEEL_SLOTS) - 64'd1) / 64'(WHEEL_SLOTS);

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_REM,
        F_PUSH
    } t_fstate;

    t_fstate                                r_state;
    tws_pkg::t_op                           r_op;
    logic [tws_pkg::INTERVAL_W-1:0]         r_x;
    logic [tws_pkg::INTERVAL_W-1:0]         r_quo;
    logic [REM_W-1:0]                       r_rem;
    logic                                   r_rep;
    logic [tws_pkg::TID_W-1:0]              r_tid;

    logic                                   accept;
    logic [tws_pkg::INTERVAL_W-1:0]         in_ivl;
    logic [PROD_W-1:0]                      prod;
    logic [tws_pkg::INTERVAL_W-1:0]         quo;
    logic [tws_pkg::INTERVAL_W-1:0]         rem_full;

    assign o_s_axis_tready = (r_state == F_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign in_ivl          = i_s_axis_tdata[tws_pkg::INTERVAL_W-1:0];

    // quotient registered in F_MUL, remainder from it in F_REM
    assign prod     = PROD_W'(r_x) * PROD_W'(RECIP);
    assign quo      = tws_pkg::INTERVAL_W'(prod >> SHIFT);
    assign rem_full = r_x - r_quo * tws_pkg::INTERVAL_W'(WHEEL_SLOTS);

    assign o_cmd_valid   = (r_state == F_PUSH);
    assign o_cmd.op      = r_op;
    assign o_cmd.rot     = r_quo;
    assign o_cmd.offset  = tws_pkg::OFS_FIELD_W'(r_rem) + tws_pkg::OFS_FIELD_W'(1);
    assign o_cmd.rep     = r_rep;
    assign o_cmd.tid     = r_tid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_rep <= i_s_axis_tdata[tws_pkg::INTERVAL_W];
                        r_tid <= i_s_axis_tdata[tws_pkg::INTERVAL_W+tws_pkg::TID_W:
                                                tws_pkg::INTERVAL_W+1];
                        r_x   <= in_ivl - tws_pkg::INTERVAL_W'(1);
                        priority if (i_s_axis_tuser == tws_pkg::MODE_TICK) begin
                            r_op    <= tws_pkg::OP_TICK;
                            r_state <= F_PUSH;
                        end else if (i_s_axis_tuser == tws_pkg::MODE_ADD) begin
                            if (in_ivl == '0) begin
                                r_op    <= tws_pkg::OP_REJECT;
                                r_state <= F_PUSH;
                            end else begin
                                r_op    <= tws_pkg::OP_ADD;
                                r_state <= F_MUL;
                            end
                        end else if (i_s_axis_tuser == tws_pkg::MODE_DELETE) begin
                            r_op    <= tws_pkg::OP_DELETE;
                            r_state <= F_PUSH;
                        end else begin
                            r_state <= F_IDLE;  // unused mode: dropped
                        end
                    end
                end
                F_MUL: begin
                    r_quo   <= quo;
                    r_state <= F_REM;
                end
                F_REM: begin
                    r_rem   <= REM_W'(rem_full);
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (i_cmd_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/tws_back.sv -----
// Back end: owns the timer table (valid flags plus entry RAM) and the
// current slot, executes commands and drives the result register.
// Uses tws_pkg and tws_ram.
`default_nettype none

module tws_back #(
    parameter int WHEEL_SLOTS   = 60,
    parameter int TIMER_ENTRIES = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cmd_valid,
    output logic                                o_cmd_ready,
    input  wire tws_pkg::t_cmd                  i_cmd,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    output logic [7:0]                          o_m_axis_tdata,
    output logic [tws_pkg::STATUS_W-1:0]        o_m_axis_tuser,
    output logic                                o_m_axis_tlast
);

    localparam int SLOT_W = $clog2(WHEEL_SLOTS);
    localparam int OFS_W  = $clog2(WHEEL_SLOTS + 1);
    localparam int IDX_W  = (TIMER_ENTRIES > 1) ? $clog2(TIMER_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(TIMER_ENTRIES + 1);
    localparam int ROT_W  = tws_pkg::INTERVAL_W;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [ROT_W-1:0]  rot;
        logic [ROT_W-1:0]  reload;
        logic [OFS_W-1:0]  offset;
        logic              rep;
    } t_entry;

    localparam int ENT_W = $bits(t_entry);

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCAN,
        B_WALK,
        B_FLUSH,
        B_EMIT
    } t_bstate;

    function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] cur,
                                                     input logic [OFS_W-1:0]  ofs);
        logic [OFS_W:0] sum;
        sum = (OFS_W+1)'(cur) + (OFS_W+1)'(ofs);
        if (sum >= (OFS_W+1)'(WHEEL_SLOTS)) begin
            sum = sum - (OFS_W+1)'(WHEEL_SLOTS);
        end
        return SLOT_W'(sum);
    endfunction

    t_bstate                         r_state, n_state;
    logic [TIMER_ENTRIES-1:0]        r_valid, n_valid;
    logic [SLOT_W-1:0]               r_cur, n_cur;
    tws_pkg::t_cmd                   r_cmd, n_cmd;
    logic [IDX_W-1:0]                r_idx, n_idx;
    logic [CNT_W-1:0]                r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]                r_pidx, n_pidx;
    logic                            r_pv, n_pv;
    logic [tws_pkg::RES_CNT_W-1:0]   r_nres, n_nres;
    logic                            r_pend_valid, n_pend_valid;
    logic [tws_pkg::NUM_W-1:0]       r_pend_num, n_pend_num;
    tws_pkg::t_status                r_res_status, n_res_status;
    logic [tws_pkg::NUM_W-1:0]       r_res_num, n_res_num;
    logic                            r_out_valid, n_out_valid;
    tws_pkg::t_status                r_out_status, n_out_status;
    logic [tws_pkg::NUM_W-1:0]       r_out_num, n_out_num;
    logic                            r_out_last, n_out_last;

    logic                            ram_we;
    logic [IDX_W-1:0]                ram_waddr;
    t_entry                          ram_wdata;
    logic                            ram_re;
    logic [IDX_W-1:0]                ram_raddr;
    logic [ENT_W-1:0]                ram_rdata;
    t_entry                          ent;

    logic                            out_free;
    logic                            hit;
    logic                            expire;
    logic                            report;
    logic                            stall;
    logic [IDX_W-1:0]                del_idx;
    logic                            del_hit;

    tws_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TIMER_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ent      = t_entry'(ram_rdata);
    assign out_free = !r_out_valid || i_m_axis_tready;

    // walk: the RAM word of entry r_pidx is on ram_rdata this cycle
    assign hit    = r_pv && r_valid[r_pidx] && (ent.slot == r_cur);
    assign expire = hit && (ent.rot == '0);
    assign report = expire && (r_nres < tws_pkg::RES_CNT_W'(tws_pkg::MAX_RESULTS));
    assign stall  = (r_state == B_WALK) && report && r_pend_valid && !out_free;

    assign del_idx = IDX_W'(i_cmd.tid);
    assign del_hit = (8'(i_cmd.tid) < 8'(TIMER_ENTRIES)) && r_valid[del_idx];

    assign o_cmd_ready     = (r_state == B_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = 8'(r_out_num);
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_cur        = r_cur;
        n_cmd        = r_cmd;
        n_idx        = r_idx;
        n_rd_idx     = r_rd_idx;
        n_pidx       = r_pidx;
        n_pv         = r_pv;
        n_nres       = r_nres;
        n_pend_valid = r_pend_valid;
        n_pend_num   = r_pend_num;
        n_res_status = r_res_status;
        n_res_num    = r_res_num;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_num    = r_out_num;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_waddr    = r_pidx;
        ram_wdata    = ent;
        ram_re       = 1'b0;
        ram_raddr    = IDX_W'(r_rd_idx);

        unique case (r_state)
            B_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd = i_cmd;
                    unique case (i_cmd.op)
                        tws_pkg::OP_TICK: begin
                            n_cur        = (r_cur == SLOT_W'(WHEEL_SLOTS - 1)) ?
                                           '0 : r_cur + SLOT_W'(1);
                            n_rd_idx     = '0;
                            n_pv         = 1'b0;
                            n_nres       = '0;
                            n_pend_valid = 1'b0;
                            n_state      = B_WALK;
                        end
                        tws_pkg::OP_ADD: begin
                            n_idx   = '0;
                            n_state = B_SCAN;
                        end
                        tws_pkg::OP_DELETE: begin
                            n_res_num = i_cmd.tid;
                            if (del_hit) begin
                                n_valid[del_idx] = 1'b0;
                                n_res_status     = tws_pkg::ST_DELETED;
                            end else begin
                                n_res_status     = tws_pkg::ST_NOT_FOUND;
                            end
                            n_state = B_EMIT;
                        end
                        tws_pkg::OP_REJECT: begin
                            n_res_status = tws_pkg::ST_REJECTED;
                            n_res_num    = '0;
                            n_state      = B_EMIT;
                        end
                        default: begin
                            n_state = B_IDLE;
                        end
                    endcase
                end
            end
            B_SCAN: begin
                // lowest free entry, one flag per cycle
                if (!r_valid[r_idx]) begin
                    ram_we           = 1'b1;
                    ram_waddr        = r_idx;
                    ram_wdata.slot   = slot_after(r_cur, OFS_W'(r_cmd.offset));
                    ram_wdata.rot    = r_cmd.rot;
                    ram_wdata.reload = r_cmd.rot;
                    ram_wdata.offset = OFS_W'(r_cmd.offset);
                    ram_wdata.rep    = r_cmd.rep;
                    n_valid[r_idx]   = 1'b1;
                    n_res_status     = tws_pkg::ST_ADDED;
                    n_res_num        = tws_pkg::NUM_W'(r_idx);
                    n_state          = B_EMIT;
                end else if (r_idx == IDX_W'(TIMER_ENTRIES - 1)) begin
                    n_res_status = tws_pkg::ST_FULL;
                    n_res_num    = '0;
                    n_state      = B_EMIT;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            B_WALK: begin
                if (!stall) begin
                    if (hit && !expire) begin
                        ram_we        = 1'b1;
                        ram_wdata.rot = ent.rot - ROT_W'(1);
                    end
                    if (expire) begin
                        if (ent.rep) begin
                            ram_we         = 1'b1;
                            ram_wdata.slot = slot_after(r_cur, ent.offset);
                            ram_wdata.rot  = ent.reload;
                        end else begin
                            n_valid[r_pidx] = 1'b0;
                        end
                    end
                    // an expiry is held back one step so its last flag is known
                    if (report) begin
                        if (r_pend_valid) begin
                            n_out_valid  = 1'b1;
                            n_out_status = tws_pkg::ST_EXPIRED;
                            n_out_num    = r_pend_num;
                            n_out_last   = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_num   = tws_pkg::NUM_W'(r_pidx);
                        n_nres       = r_nres + tws_pkg::RES_CNT_W'(1);
                    end
                    if (r_rd_idx != CNT_W'(TIMER_ENTRIES)) begin
                        ram_re   = 1'b1;
                        n_pidx   = IDX_W'(r_rd_idx);
                        n_pv     = 1'b1;
                        n_rd_idx = r_rd_idx + CNT_W'(1);
                    end else begin
                        n_pv = 1'b0;
                        if (!r_pv) begin
                            n_state = B_FLUSH;
                        end
                    end
                end
            end
            B_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = B_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = tws_pkg::ST_EXPIRED;
                    n_out_num    = r_pend_num;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = B_IDLE;
                end
            end
            B_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_num    = r_res_num;
                    n_out_last   = 1'b1;
                    n_state      = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_valid      <= '0;
            r_cur        <= '0;
            r_pv         <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_cur        <= n_cur;
            r_pv         <= n_pv;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
        r_cmd        <= n_cmd;
        r_idx        <= n_idx;
        r_rd_idx     <= n_rd_idx;
        r_pidx       <= n_pidx;
        r_nres       <= n_nres;
        r_pend_num   <= n_pend_num;
        r_res_status <= n_res_status;
        r_res_num    <= n_res_num;
        r_out_status <= n_out_status;
        r_out_num    <= n_out_num;
        r_out_last   <= n_out_last;
    end

endmodule

`default_nettype wire

// ----- src/timing_wheel_scheduler_core.sv -----
// Hashed timing wheel scheduler, top level: front end, command queue,
// back end. Uses tws_pkg, tws_front, tws_fifo and tws_back.
//
// Input words carry a mode in tuser (tick, add, delete) and the interval,
// repeat flag and timer id in tdata. Each add, reject or delete gives one
// result word; a tick gives one expiry word per expired timer (at most 16),
// in ascending entry order, tlast on the final one, and none if nothing
// expires. Status travels in tuser, the entry number in tdata.
// An add passes through a reciprocal divide in the front end, then a scan
// of the valid flags, one per cycle; a tick walks the entry RAM one entry
// per cycle while the output is not stalled. The front end takes a new word
// only once the previous command has gone into the queue, and the back end
// takes a new command only once the previous one has finished.
// Reset clears the valid flags, the current slot and all handshakes; the
// entry RAM needs no clearing. When the receiver stalls, results wait in
// the output register and the tick walk pauses; the queue then fills and
// the input side stops.
`default_nettype none

module timing_wheel_scheduler_core #(
    parameter int WHEEL_SLOTS   = 60,
    parameter int TIMER_ENTRIES = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire logic [31:0]                    i_s_axis_tdata,  // interval, repeat_req, timer_id
    input  wire logic [tws_pkg::MODE_W-1:0]     i_s_axis_tuser,  // mode
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    output logic [7:0]                          o_m_axis_tdata,  // timer_number
    output logic [tws_pkg::STATUS_W-1:0]        o_m_axis_tuser,  // status
    output logic                                o_m_axis_tlast
);

    localparam int CMD_W = $bits(tws_pkg::t_cmd);

    logic          fr_valid;
    logic          fr_ready;
    tws_pkg::t_cmd fr_cmd;
    logic          bk_valid;
    logic          bk_ready;
    logic [CMD_W-1:0] bk_data;

    tws_front #(
        .WHEEL_SLOTS (WHEEL_SLOTS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_cmd_valid     (fr_valid),
        .i_cmd_ready     (fr_ready),
        .o_cmd           (fr_cmd)
    );

    tws_fifo #(
        .WIDTH (CMD_W)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fr_valid),
        .o_wr_ready (fr_ready),
        .i_wr_data  (fr_cmd),
        .o_rd_valid (bk_valid),
        .i_rd_ready (bk_ready),
        .o_rd_data  (bk_data)
    );

    tws_back #(
        .WHEEL_SLOTS   (WHEEL_SLOTS),
        .TIMER_ENTRIES (TIMER_ENTRIES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (bk_valid),
        .o_cmd_ready     (bk_ready),
        .i_cmd           (tws_pkg::t_cmd'(bk_data)),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // a non-zero add occupies the divider, so input closes next cycle
    a_add_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == tws_pkg::MODE_ADD &&
        i_s_axis_tdata[tws_pkg::INTERVAL_W-1:0] != '0 |=> !o_s_axis_tready)
        else $error("front end took a word while dividing");

    // unused modes are dropped without tying up the front end
    a_drop_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser != tws_pkg::MODE_TICK &&
        i_s_axis_tuser != tws_pkg::MODE_ADD && i_s_axis_tuser != tws_pkg::MODE_DELETE
        |=> o_s_axis_tready)
        else $error("unused mode stalled the front end");

    // only expiry words can be followed by more words from the same item
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != tws_pkg::ST_EXPIRED |-> o_m_axis_tlast)
        else $error("non-expiry result without tlast");

    // queue handshake into the back end only while it is free to dispatch
    a_queue_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk_valid && bk_ready |=> !bk_ready)
        else $error("back end took two commands back to back");

endmodule

`default_nettype wire
